### hdl/cdwu_pkg.sv
`default_nettype none
package cdwu_pkg;

   typedef enum logic [2:0] {
      KIND_LOAD_VIS  = 3'd0,
      KIND_LOAD_HID  = 3'd1,
      KIND_WR_WEIGHT = 3'd2,
      KIND_WR_BIAS   = 3'd3,
      KIND_RD_WEIGHT = 3'd4,
      KIND_RD_BIAS   = 3'd5,
      KIND_UPDATE    = 3'd6,
      KIND_NOP       = 3'd7
   } kind_type;

   localparam logic [1:0] CSR_VISIBLE_COUNT = 2'd0;
   localparam logic [1:0] CSR_HIDDEN_COUNT  = 2'd1;
   localparam logic [1:0] CSR_LEARN_RATE    = 2'd2;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int COUNT_WIDTH    = 7;
   localparam int RATE_WIDTH     = 16;

   localparam int ACT_FRAC    = 12;
   localparam int WEIGHT_FRAC = 24;
   localparam int RATE_FRAC   = 16;
   localparam int PROD_SHIFT  = 2 * ACT_FRAC + RATE_FRAC - WEIGHT_FRAC;
   localparam int BIAS_SHIFT  = ACT_FRAC + RATE_FRAC - WEIGHT_FRAC;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_HREAD,
      ST_WREAD,
      ST_WCALC,
      ST_WWRITE,
      ST_BWRITE,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

### hdl/cdwu_ram.sv
`default_nettype none
module cdwu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### hdl/cdwu_delta.sv
`default_nettype none
// Datapath: products registered, then rate scaling, rounding and saturation.
module cdwu_delta #(
   parameter int ACT_WIDTH    = 16,
   parameter int WEIGHT_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           bias_mode,
   input  wire logic signed [ACT_WIDTH-1:0]    vis_pos,
   input  wire logic signed [ACT_WIDTH-1:0]    vis_neg,
   input  wire logic signed [ACT_WIDTH-1:0]    hid_pos,
   input  wire logic signed [ACT_WIDTH-1:0]    hid_neg,
   input  wire logic [cdwu_pkg::RATE_WIDTH-1:0] rate,
   input  wire logic signed [WEIGHT_WIDTH-1:0] old_value,
   output logic signed [WEIGHT_WIDTH-1:0]      new_value,
   output logic                                clipped
);

   localparam int DW = 2 * ACT_WIDTH + 1;
   localparam int SW = DW + cdwu_pkg::RATE_WIDTH + 1;

   logic signed [DW-1:0] diff_ff, diff_in;
   logic                 bias_ff;
   logic signed [SW-1:0] scaled;
   logic signed [SW-1:0] rounded;
   logic signed [SW-1:0] total;
   logic signed [SW-1:0] hi_lim, lo_lim;

   always_comb begin
      if (bias_mode) begin
         diff_in = DW'(hid_pos) - DW'(hid_neg);
      end else begin
         // widen before multiplying so the full product is kept
         diff_in = (DW'(vis_pos) * DW'(hid_pos)) - (DW'(vis_neg) * DW'(hid_neg));
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      bias_ff <= bias_mode;
   end

   always_comb begin
      scaled = SW'(diff_ff) * $signed({1'b0, rate});
      if (bias_ff) begin
         rounded = (scaled + (SW'(1) <<< (cdwu_pkg::BIAS_SHIFT - 1)))
                   >>> cdwu_pkg::BIAS_SHIFT;
      end else begin
         rounded = (scaled + (SW'(1) <<< (cdwu_pkg::PROD_SHIFT - 1)))
                   >>> cdwu_pkg::PROD_SHIFT;
      end
      total  = SW'(old_value) + rounded;
      hi_lim = SW'({1'b0, {(WEIGHT_WIDTH-1){1'b1}}});
      lo_lim = -hi_lim - SW'(1);
      clipped = 1'b0;
      if (total > hi_lim) begin
         new_value = hi_lim[WEIGHT_WIDTH-1:0];
         clipped   = 1'b1;
      end else if (total < lo_lim) begin
         new_value = lo_lim[WEIGHT_WIDTH-1:0];
         clipped   = 1'b1;
      end else begin
         new_value = total[WEIGHT_WIDTH-1:0];
      end
   end

endmodule
`default_nettype wire

### hdl/cd_weight_update_engine.sv
`default_nettype none
// RBM contrastive-divergence weight update engine.
// Request channel (req_valid/req_stall) carries one item: kind, indices,
// activations and a weight/bias value. Response channel (rsp_valid/rsp_stall)
// returns one item per request: read_value, saturated, index_error.
// Loads, writes, reads: from accept they pass ST_ACCESS and ST_RESP before rsp_valid; the block
// takes one item at a time and accepts the next once the response register
// is taken (the response register frees as soon as rsp_stall is low).
// Update: per hidden unit, one hidden-vector read (ST_HREAD), then for every
// visible unit a read/compute/write pass (ST_WREAD, ST_WCALC, ST_WWRITE) over the weight
// memory, then a bias update in ST_BWRITE, before rsp_valid.
// Weights live in a MAX_VISIBLE*MAX_HIDDEN synchronous RAM addressed
// visible*MAX_HIDDEN+hidden; vectors and biases in small RAMs.
// Reset clears control and the config registers (counts 64, rate 655);
// stored contents are undefined until written, and no clearing pass runs.
// A stalled response holds its payload; no new item is accepted meanwhile.
module cd_weight_update_engine #(
   parameter int MAX_VISIBLE  = 64,
   parameter int MAX_HIDDEN   = 64,
   parameter int ACT_WIDTH    = 16,
   parameter int WEIGHT_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [cdwu_pkg::CSR_ADDR_WIDTH-1:0] csr_index,
   input  wire logic [cdwu_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [2:0]                          req_kind,
   input  wire logic [5:0]                          req_visible_index,
   input  wire logic [5:0]                          req_hidden_index,
   input  wire logic signed [ACT_WIDTH-1:0]         req_pos_value,
   input  wire logic signed [ACT_WIDTH-1:0]         req_neg_value,
   input  wire logic signed [WEIGHT_WIDTH-1:0]      req_write_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [WEIGHT_WIDTH-1:0]           rsp_read_value,
   output logic                                     rsp_saturated,
   output logic                                     rsp_index_error
);

   localparam int VW = (MAX_VISIBLE > 1) ? $clog2(MAX_VISIBLE) : 1;
   localparam int HW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
   localparam int WDEPTH = MAX_VISIBLE * MAX_HIDDEN;
   localparam int WAW = $clog2(WDEPTH) > 0 ? $clog2(WDEPTH) : 1;
   localparam int CW = cdwu_pkg::COUNT_WIDTH;

   logic [CW-1:0] vcount_ff, hcount_ff;
   logic [cdwu_pkg::RATE_WIDTH-1:0] rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CW'(64);
         hcount_ff <= CW'(64);
         rate_ff   <= cdwu_pkg::RATE_WIDTH'(655);
      end else if (csr_write) begin
         unique case (csr_index)
            cdwu_pkg::CSR_VISIBLE_COUNT: vcount_ff <= csr_data[CW-1:0];
            cdwu_pkg::CSR_HIDDEN_COUNT:  hcount_ff <= csr_data[CW-1:0];
            cdwu_pkg::CSR_LEARN_RATE:    rate_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // effective counts, clamped to the maxima (12 bits wide, holding values up to 4095)
   logic [11:0] vc, hc;
   assign vc = (12'(vcount_ff) > 12'(MAX_VISIBLE)) ? 12'(MAX_VISIBLE) : 12'(vcount_ff);
   assign hc = (12'(hcount_ff) > 12'(MAX_HIDDEN)) ? 12'(MAX_HIDDEN) : 12'(hcount_ff);

   cdwu_pkg::state_type state_ff, state_in;
   cdwu_pkg::kind_type  kind_ff, kind_in;
   logic [5:0] vidx_ff, vidx_in, hidx_ff, hidx_in;
   logic signed [ACT_WIDTH-1:0] pos_ff, pos_in, neg_ff, neg_in;
   logic signed [WEIGHT_WIDTH-1:0] wval_ff, wval_in;
   logic [11:0] v_ff, v_in, h_ff, h_in;
   logic sat_ff, sat_in;
   logic err_ff, err_in;
   logic signed [WEIGHT_WIDTH-1:0] rdv_ff, rdv_in;
   logic rspv_ff, rspv_in;
   logic clip_ff, clip_in;

   logic accept;
   logic vok, hok;

   assign req_stall = (state_ff != cdwu_pkg::ST_IDLE) || rspv_ff;
   assign accept    = req_valid && !req_stall;
   assign vok = 12'(vidx_ff) < vc;
   assign hok = 12'(hidx_ff) < hc;

   // memory ports
   logic vv_we, hv_we, w_we, b_we;
   logic [VW-1:0] vv_wa, vv_ra;
   logic [HW-1:0] hv_wa, hv_ra, b_wa, b_ra;
   logic [WAW-1:0] w_wa, w_ra;
   logic [2*ACT_WIDTH-1:0] vv_rd, hv_rd;
   logic [WEIGHT_WIDTH-1:0] w_wd, w_rd, b_wd, b_rd;

   cdwu_ram #(.WIDTH(2*ACT_WIDTH), .DEPTH(MAX_VISIBLE)) u_vis (
      .clock, .wr_en(vv_we), .wr_addr(vv_wa), .wr_data({pos_ff, neg_ff}),
      .rd_addr(vv_ra), .rd_data(vv_rd));
   cdwu_ram #(.WIDTH(2*ACT_WIDTH), .DEPTH(MAX_HIDDEN)) u_hid (
      .clock, .wr_en(hv_we), .wr_addr(hv_wa), .wr_data({pos_ff, neg_ff}),
      .rd_addr(hv_ra), .rd_data(hv_rd));
   cdwu_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(WDEPTH)) u_weight (
      .clock, .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(w_ra), .rd_data(w_rd));
   cdwu_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(MAX_HIDDEN)) u_bias (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(b_rd));

   // hidden pair held for the whole row
   logic signed [ACT_WIDTH-1:0] hpos_ff, hpos_in, hneg_ff, hneg_in;
   logic bias_mode;
   logic signed [WEIGHT_WIDTH-1:0] dp_old, dp_new;
   logic dp_clip;

   cdwu_delta #(.ACT_WIDTH(ACT_WIDTH), .WEIGHT_WIDTH(WEIGHT_WIDTH)) u_delta (
      .clock,
      .bias_mode,
      .vis_pos  (vv_rd[2*ACT_WIDTH-1:ACT_WIDTH]),
      .vis_neg  (vv_rd[ACT_WIDTH-1:0]),
      .hid_pos  (hpos_ff),
      .hid_neg  (hneg_ff),
      .rate     (rate_ff),
      .old_value(dp_old),
      .new_value(dp_new),
      .clipped  (dp_clip)
   );

   logic [WAW-1:0] acc_addr, upd_addr;
   assign acc_addr = WAW'(vidx_ff[VW-1:0]) * WAW'(MAX_HIDDEN) + WAW'(hidx_ff[HW-1:0]);
   assign upd_addr = WAW'(v_ff[VW-1:0]) * WAW'(MAX_HIDDEN) + WAW'(h_ff[HW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdwu_pkg::ST_IDLE;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
      end
      kind_ff <= kind_in;
      vidx_ff <= vidx_in;
      hidx_ff <= hidx_in;
      pos_ff  <= pos_in;
      neg_ff  <= neg_in;
      wval_ff <= wval_in;
      v_ff    <= v_in;
      h_ff    <= h_in;
      sat_ff  <= sat_in;
      err_ff  <= err_in;
      rdv_ff  <= rdv_in;
      hpos_ff <= hpos_in;
      hneg_ff <= hneg_in;
      clip_ff <= clip_in;
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      vidx_in  = vidx_ff;
      hidx_in  = hidx_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      wval_in  = wval_ff;
      v_in     = v_ff;
      h_in     = h_ff;
      sat_in   = sat_ff;
      err_in   = err_ff;
      rdv_in   = rdv_ff;
      hpos_in  = hpos_ff;
      hneg_in  = hneg_ff;
      clip_in  = clip_ff;
      rspv_in  = rspv_ff && rsp_stall;
      vv_we = 1'b0; hv_we = 1'b0; w_we = 1'b0; b_we = 1'b0;
      vv_wa = vidx_ff[VW-1:0];
      hv_wa = hidx_ff[HW-1:0];
      vv_ra = v_ff[VW-1:0];
      hv_ra = h_ff[HW-1:0];
      w_wa  = acc_addr;
      w_ra  = acc_addr;
      w_wd  = wval_ff;
      b_wa  = hidx_ff[HW-1:0];
      b_ra  = hidx_ff[HW-1:0];
      b_wd  = wval_ff;
      bias_mode = 1'b0;
      dp_old = w_rd;

      unique case (state_ff)
         cdwu_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in = cdwu_pkg::kind_type'(req_kind);
               vidx_in = req_visible_index;
               hidx_in = req_hidden_index;
               pos_in  = req_pos_value;
               neg_in  = req_neg_value;
               wval_in = req_write_value;
               sat_in  = 1'b0;
               err_in  = 1'b0;
               rdv_in  = '0;
               v_in    = '0;
               h_in    = '0;
               if (cdwu_pkg::kind_type'(req_kind) == cdwu_pkg::KIND_UPDATE) begin
                  state_in = cdwu_pkg::ST_HREAD;
               end else begin
                  state_in = cdwu_pkg::ST_ACCESS;
               end
            end
         end
         cdwu_pkg::ST_ACCESS: begin
            // issue write or read; read data lands next cycle
            state_in = cdwu_pkg::ST_RESP;
            unique case (kind_ff)
               cdwu_pkg::KIND_LOAD_VIS: begin
                  vv_we = vok; err_in = !vok;
               end
               cdwu_pkg::KIND_LOAD_HID: begin
                  hv_we = hok; err_in = !hok;
               end
               cdwu_pkg::KIND_WR_WEIGHT: begin
                  w_we = vok && hok; err_in = !(vok && hok);
               end
               cdwu_pkg::KIND_WR_BIAS: begin
                  b_we = hok; err_in = !hok;
               end
               cdwu_pkg::KIND_RD_WEIGHT: err_in = !(vok && hok);
               cdwu_pkg::KIND_RD_BIAS:   err_in = !hok;
               default: ;
            endcase
         end
         cdwu_pkg::ST_RESP: begin
            if (kind_ff == cdwu_pkg::KIND_RD_WEIGHT && !err_ff) begin
               rdv_in = w_rd;
            end else if (kind_ff == cdwu_pkg::KIND_RD_BIAS && !err_ff) begin
               rdv_in = b_rd;
            end
            rspv_in  = 1'b1;
            state_in = cdwu_pkg::ST_IDLE;
         end
         cdwu_pkg::ST_HREAD: begin
            // h_ff addresses hidden RAM and bias RAM; data next cycle
            b_ra = h_ff[HW-1:0];
            if (h_ff >= hc) begin
               rspv_in  = 1'b1;
               state_in = cdwu_pkg::ST_IDLE;
            end else begin
               state_in = cdwu_pkg::ST_WREAD;
            end
         end
         cdwu_pkg::ST_WREAD: begin
            // first pass captures hidden pair; v_ff indexes visible and weight RAM
            if (v_ff == 12'd0) begin
               hpos_in = hv_rd[2*ACT_WIDTH-1:ACT_WIDTH];
               hneg_in = hv_rd[ACT_WIDTH-1:0];
            end
            w_ra = upd_addr;
            // no visible units: only the bias moves
            if (vc == 12'd0) begin
               state_in = cdwu_pkg::ST_BWRITE;
            end else begin
               state_in = cdwu_pkg::ST_WCALC;
            end
         end
         cdwu_pkg::ST_WCALC: begin
            // vv_rd valid; products register inside the datapath
            w_ra = upd_addr;
            state_in = cdwu_pkg::ST_WWRITE;
         end
         cdwu_pkg::ST_WWRITE: begin
            dp_old = w_rd;
            w_we = 1'b1;
            w_wa = upd_addr;
            w_wd = dp_new;
            if (dp_clip) sat_in = 1'b1;
            if (v_ff + 12'd1 >= vc) begin
               v_in = '0;
               b_ra = h_ff[HW-1:0];
               state_in = cdwu_pkg::ST_BWRITE;
            end else begin
               v_in = v_ff + 12'd1;
               state_in = cdwu_pkg::ST_WREAD;
            end
         end
         cdwu_pkg::ST_BWRITE: begin
            // two-phase: clip_ff marks the second lap, when the bias result is ready
            bias_mode = 1'b1;
            dp_old = b_rd;
            b_ra = h_ff[HW-1:0];
            if (!clip_ff) begin
               clip_in = 1'b1; // use as phase flag: product stage now loaded
            end else begin
               clip_in = 1'b0;
               b_we = 1'b1;
               b_wa = h_ff[HW-1:0];
               b_wd = dp_new;
               if (dp_clip) sat_in = 1'b1;
               h_in = h_ff + 12'd1;
               state_in = cdwu_pkg::ST_HREAD;
            end
         end
         default: state_in = cdwu_pkg::ST_IDLE;
      endcase
      if (state_ff == cdwu_pkg::ST_IDLE) clip_in = 1'b0;
   end

   assign rsp_valid       = rspv_ff;
   assign rsp_read_value  = rdv_ff;
   assign rsp_saturated   = sat_ff;
   assign rsp_index_error = err_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != cdwu_pkg::ST_IDLE) |-> req_stall)
      else $error("item accepted while busy");
   a_update_no_err: assert property (@(posedge clock) disable iff (reset)
      (rspv_ff && kind_ff == cdwu_pkg::KIND_UPDATE) |-> !err_ff)
      else $error("update flagged index error");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rspv_ff && rsp_stall) |=> (rspv_ff && $stable(rdv_ff)))
      else $error("stalled response changed");
   a_wwrite_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdwu_pkg::ST_WWRITE) |-> (v_ff < vc && h_ff < hc))
      else $error("update index out of range");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int N_UNITS = 64;

   typedef struct {
      logic signed [31:0] read_value;
      logic               saturated;
      logic               index_error;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [cdwu_pkg::CSR_ADDR_WIDTH-1:0] csr_index = '0;
   logic [cdwu_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_kind = '0;
   logic [5:0] req_visible_index = '0;
   logic [5:0] req_hidden_index = '0;
   logic signed [15:0] req_pos_value = '0;
   logic signed [15:0] req_neg_value = '0;
   logic signed [31:0] req_write_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [31:0] rsp_read_value;
   logic rsp_saturated;
   logic rsp_index_error;

   cd_weight_update_engine u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_visible_index(req_visible_index), .req_hidden_index(req_hidden_index),
      .req_pos_value(req_pos_value), .req_neg_value(req_neg_value),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_value(rsp_read_value),
      .rsp_saturated(rsp_saturated), .rsp_index_error(rsp_index_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [6:0]  visible_cnt = 7'd64;
   logic [6:0]  hidden_cnt = 7'd64;
   logic [15:0] rate_q16 = 16'd655;
   logic signed [15:0] vis_pos[N_UNITS];
   logic signed [15:0] vis_neg[N_UNITS];
   logic signed [15:0] hid_pos[N_UNITS];
   logic signed [15:0] hid_neg[N_UNITS];
   logic signed [31:0] weight_mem[N_UNITS*N_UNITS];
   logic signed [31:0] bias_mem[N_UNITS];

   rsp_item_type expected_rsp[$];
   int  error_count = 0;
   bit  idle_on = 1'b0;
   int  hold_cycles = 0;

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic signed [31:0] sat_sum(input longint a, input longint d,
                                                   inout logic sat);
      longint s;
      s = a + d;
      if (s > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (s < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return s[31:0];
   endfunction

   function automatic rsp_item_type compute_cd(input cdwu_pkg::kind_type k,
                                               input logic [5:0] vi,
                                               input logic [5:0] hi,
                                               input logic signed [15:0] pv,
                                               input logic signed [15:0] nv,
                                               input logic signed [31:0] wv);
      rsp_item_type r;
      int vc, hc;
      bit vok, hok;
      longint diff, d, rate;
      vc = (visible_cnt > 64) ? 64 : int'(visible_cnt);
      hc = (hidden_cnt > 64) ? 64 : int'(hidden_cnt);
      vok = int'(vi) < vc;
      hok = int'(hi) < hc;
      rate = longint'(rate_q16);
      r.read_value = '0;
      r.saturated = 1'b0;
      r.index_error = 1'b0;
      case (k)
         cdwu_pkg::KIND_LOAD_VIS: begin
            if (vok) begin
               vis_pos[vi] = pv;
               vis_neg[vi] = nv;
            end else r.index_error = 1'b1;
         end
         cdwu_pkg::KIND_LOAD_HID: begin
            if (hok) begin
               hid_pos[hi] = pv;
               hid_neg[hi] = nv;
            end else r.index_error = 1'b1;
         end
         cdwu_pkg::KIND_WR_WEIGHT: begin
            if (vok && hok) weight_mem[vi*N_UNITS+hi] = wv;
            else r.index_error = 1'b1;
         end
         cdwu_pkg::KIND_WR_BIAS: begin
            if (hok) bias_mem[hi] = wv;
            else r.index_error = 1'b1;
         end
         cdwu_pkg::KIND_RD_WEIGHT: begin
            if (vok && hok) r.read_value = weight_mem[vi*N_UNITS+hi];
            else r.index_error = 1'b1;
         end
         cdwu_pkg::KIND_RD_BIAS: begin
            if (hok) r.read_value = bias_mem[hi];
            else r.index_error = 1'b1;
         end
         cdwu_pkg::KIND_UPDATE: begin
            for (int h = 0; h < hc; h++) begin
               for (int v = 0; v < vc; v++) begin
                  diff = longint'(vis_pos[v]) * longint'(hid_pos[h])
                       - longint'(vis_neg[v]) * longint'(hid_neg[h]);
                  d = (diff * rate + (64'sd1 <<< (cdwu_pkg::PROD_SHIFT-1)))
                      >>> cdwu_pkg::PROD_SHIFT;
                  weight_mem[v*N_UNITS+h] = sat_sum(weight_mem[v*N_UNITS+h], d,
                                                    r.saturated);
               end
               diff = (longint'(hid_pos[h]) - longint'(hid_neg[h])) * rate;
               d = (diff + (64'sd1 <<< (cdwu_pkg::BIAS_SHIFT-1))) >>> cdwu_pkg::BIAS_SHIFT;
               bias_mem[h] = sat_sum(bias_mem[h], d, r.saturated);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(input cdwu_pkg::kind_type k, input logic [5:0] vi,
                            input logic [5:0] hi,
                            input logic signed [15:0] pv, input logic signed [15:0] nv,
                            input logic signed [31:0] wv);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 19)) : 0;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= k;
      req_visible_index <= vi;
      req_hidden_index <= hi;
      req_pos_value <= pv;
      req_neg_value <= nv;
      req_write_value <= wv;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(compute_cd(k, vi, hi, pv, nv, wv));
   endtask

   task automatic drain;
      @(negedge clock) req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock) csr_write <= 1'b0;
      case (idx)
         cdwu_pkg::CSR_VISIBLE_COUNT: visible_cnt = val[6:0];
         cdwu_pkg::CSR_HIDDEN_COUNT:  hidden_cnt = val[6:0];
         cdwu_pkg::CSR_LEARN_RATE:    rate_q16 = val;
         default: ;
      endcase
   endtask

   task automatic configure(input int vc, input int hc, input int rate);
      drain();
      set_reg(cdwu_pkg::CSR_VISIBLE_COUNT, 16'(vc));
      set_reg(cdwu_pkg::CSR_HIDDEN_COUNT, 16'(hc));
      set_reg(cdwu_pkg::CSR_LEARN_RATE, 16'(rate));
   endtask

   // result side
   initial begin
      int n;
      rsp_item_type e;
      forever begin
         n = idle_on ? int'($urandom_range(0, 19)) : 0;
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
         end
         if (n > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (expected_rsp.size() == 0) begin
            report("result with no item pending");
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_read_value !== e.read_value)
               report($sformatf("read_value %h, want %h", rsp_read_value, e.read_value));
            if (rsp_saturated !== e.saturated)
               report($sformatf("saturated %b, want %b", rsp_saturated, e.saturated));
            if (rsp_index_error !== e.index_error)
               report($sformatf("index_error %b, want %b", rsp_index_error,
                                e.index_error));
         end
      end
   end

   // write every entry that later tests read or update: all visible units,
   // hidden units and biases 0..7, weights for v<8,h<8 and for h<2
   task automatic test_fill;
      idle_on = 1'b0;
      for (int i = 0; i < N_UNITS; i++)
         send_item(cdwu_pkg::KIND_LOAD_VIS, 6'(i), 6'd0, 16'($urandom), 16'($urandom), 0);
      for (int i = 0; i < 8; i++) begin
         send_item(cdwu_pkg::KIND_LOAD_HID, 6'd0, 6'(i), 16'($urandom), 16'($urandom), 0);
         send_item(cdwu_pkg::KIND_WR_BIAS, 6'd0, 6'(i), 0, 0, 32'($urandom));
      end
      for (int v = 0; v < N_UNITS; v++)
         for (int h = 0; h < 8; h++)
            if (v < 8 || h < 2)
               send_item(cdwu_pkg::KIND_WR_WEIGHT, 6'(v), 6'(h), 0, 0,
                         $urandom_range(0, 3) == 0 ? 32'sd0 : 32'($urandom));
   endtask

   task automatic test_directed;
      idle_on = 1'b1;
      configure(1, 1, 16'hffff);
      send_item(cdwu_pkg::KIND_LOAD_VIS, 0, 0, 16'sh7fff, 16'sh8000, 0);
      send_item(cdwu_pkg::KIND_LOAD_HID, 0, 0, 16'sh7fff, 16'sh8000, 0);
      send_item(cdwu_pkg::KIND_WR_WEIGHT, 0, 0, 0, 0, 32'sh7fff0000);
      send_item(cdwu_pkg::KIND_WR_BIAS, 0, 0, 0, 0, 32'sh7ffffff0);
      send_item(cdwu_pkg::KIND_UPDATE, 6'h3f, 6'h3f, 0, 0, 0);   // bias clips high
      send_item(cdwu_pkg::KIND_RD_WEIGHT, 0, 0, 0, 0, 0);
      send_item(cdwu_pkg::KIND_RD_BIAS, 0, 0, 0, 0, 0);
      send_item(cdwu_pkg::KIND_LOAD_HID, 0, 0, 16'sh8000, 16'sh7fff, 0);
      send_item(cdwu_pkg::KIND_WR_WEIGHT, 0, 0, 0, 0, 32'sh80000000);
      send_item(cdwu_pkg::KIND_WR_BIAS, 0, 0, 0, 0, 32'sh80000000);
      send_item(cdwu_pkg::KIND_UPDATE, 0, 0, 0, 0, 0);            // bias clips low
      send_item(cdwu_pkg::KIND_RD_WEIGHT, 0, 0, 0, 0, 0);
      // indices past the counts
      send_item(cdwu_pkg::KIND_LOAD_VIS, 1, 0, 1, 1, 0);
      send_item(cdwu_pkg::KIND_LOAD_HID, 0, 6'h3f, 1, 1, 0);
      send_item(cdwu_pkg::KIND_WR_WEIGHT, 6'h3f, 0, 0, 0, 5);
      send_item(cdwu_pkg::KIND_WR_BIAS, 0, 1, 0, 0, 5);
      send_item(cdwu_pkg::KIND_RD_WEIGHT, 0, 6'h3f, 0, 0, 0);
      send_item(cdwu_pkg::KIND_RD_BIAS, 0, 2, 0, 0, 0);
      send_item(cdwu_pkg::KIND_NOP, 6'h3f, 6'h3f, 16'shffff, 16'shffff, 32'shffffffff);
      // zero counts: nothing valid, update is empty
      configure(0, 0, 0);
      send_item(cdwu_pkg::KIND_LOAD_VIS, 0, 0, 3, 3, 0);
      send_item(cdwu_pkg::KIND_RD_BIAS, 0, 0, 0, 0, 0);
      send_item(cdwu_pkg::KIND_UPDATE, 0, 0, 0, 0, 0);
      // counts above the maximum act as full size; unknown register ignored
      configure(127, 127, 0);
      set_reg(CSR_UNUSED, 16'h0001);
      send_item(cdwu_pkg::KIND_LOAD_HID, 0, 6'h3f, 1, 1, 0);
      send_item(cdwu_pkg::KIND_WR_WEIGHT, 6'h3f, 6'h3f, 0, 0, 9);
      send_item(cdwu_pkg::KIND_RD_WEIGHT, 6'h3f, 6'h3f, 0, 0, 0);
      send_item(cdwu_pkg::KIND_RD_WEIGHT, 6'h3f, 1, 0, 0, 0);
      send_item(cdwu_pkg::KIND_RD_BIAS, 0, 7, 0, 0, 0);
   endtask

   task automatic test_full_update;
      configure(64, 2, 655);
      send_item(cdwu_pkg::KIND_UPDATE, 0, 0, 0, 0, 0);
      send_item(cdwu_pkg::KIND_RD_WEIGHT, 6'h3f, 1, 0, 0, 0);
      send_item(cdwu_pkg::KIND_RD_BIAS, 0, 1, 0, 0, 0);
   endtask

   task automatic random_phase(input int vc, input int hc, input int rate, input int n);
      cdwu_pkg::kind_type k;
      logic [5:0] vi, hi;
      int vlim, hlim;
      configure(vc, hc, rate);
      vlim = (vc > 64) ? 64 : vc;
      hlim = (hc > 64) ? 64 : hc;
      for (int i = 0; i < n; i++) begin
         k = cdwu_pkg::kind_type'($urandom_range(0, 7));
         if (k == cdwu_pkg::KIND_UPDATE && $urandom_range(0, 3) != 0)
            k = cdwu_pkg::KIND_RD_WEIGHT;
         vi = ($urandom_range(0, 7) == 0 || vlim == 0) ? 6'($urandom)
                                                      : 6'($urandom_range(0, vlim - 1));
         hi = ($urandom_range(0, 7) == 0 || hlim == 0) ? 6'($urandom)
                                                      : 6'($urandom_range(0, hlim - 1));
         send_item(k, vi, hi, 16'($urandom), 16'($urandom), 32'($urandom));
      end
   endtask

   task automatic test_random;
      idle_on = 1'b1;
      random_phase(4, 3, int'($urandom), 70);
      random_phase(1, 8, 16'hffff, 60);
      random_phase(8, 1, 0, 60);
      idle_on = 1'b0;
      random_phase(5, 5, int'($urandom), 50);
      idle_on = 1'b1;
      random_phase(int'($urandom_range(1, 6)), int'($urandom_range(1, 6)),
                   int'($urandom), 70);
      random_phase(64, 2, int'($urandom), 30);
   endtask

   task automatic test_backpressure;
      idle_on = 1'b0;
      configure(3, 3, 1000);
      hold_cycles = 300;
      for (int i = 0; i < 12; i++)
         send_item(cdwu_pkg::kind_type'($urandom_range(0, 6)), 6'($urandom_range(0, 3)),
                   6'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                   32'($urandom));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_fill();
      test_directed();
      test_full_update();
      test_random();
      test_backpressure();
      drain();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
